@@ hdl/hhmc_pkg.sv @@
// Shared constants for the headset hook multi-click detector.
package hhmc_pkg;

    // Operation carried in the input tuser bit
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_HOOK_CODE    = 3'd0;
    localparam logic [2:0] REG_DOUBLE_CODE  = 3'd1;
    localparam logic [2:0] REG_TRIPLE_CODE  = 3'd2;
    localparam logic [2:0] REG_ENABLED_MASK = 3'd3;
    localparam logic [2:0] REG_CLICK_WINDOW = 3'd4;
    localparam logic [2:0] REG_LONG_PRESS   = 3'd5;

    // Register reset values
    localparam int unsigned HOOK_CODE_RST    = 16384;
    localparam int unsigned DOUBLE_CODE_RST  = 2048;
    localparam int unsigned TRIPLE_CODE_RST  = 1024;
    localparam int unsigned ENABLED_MASK_RST = 65535;
    localparam int unsigned CLICK_WINDOW_RST = 500;
    localparam int unsigned LONG_PRESS_RST   = 500;

    // Click counter saturates here
    localparam logic [7:0] CLICK_MAX = 8'd255;

    // Output word queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

@@ hdl/headset_hook_multi_click_core.sv @@
// Headset hook multi-click and long-press detector, top level.
//
// Takes jack status reports and time ticks, one word per clock when the output
// side keeps up. An accepted word is registered, then handled in one pass of
// compare-and-update logic in the next cycle, which pushes zero, one or two
// result words into a four-word output queue. Result words leave at one per
// clock while the output side is ready; input tready drops only when the
// queue cannot take the worst case of two results from both the word in
// flight and the next one. A hook press starts a long-press timer; a short
// press-release counts a click and restarts the click window; at window
// expiry the hook, double or triple code is sent, if the jack is still bound,
// followed by a release word 0. Registers are to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
module headset_hook_multi_click_core #(
    parameter int STATUS_BITS = 16,
    parameter int TIMER_BITS  = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input stream
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [((STATUS_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,  // status
    input  logic                                    i_s_axis_tuser,  // operation
    // output stream
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    output logic [((STATUS_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata,  // report_status
    output logic                                    o_m_axis_tuser,  // from_click
    output logic                                    o_m_axis_tlast,  // last
    // configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [4:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import hhmc_pkg::*;

    localparam int DW = ((STATUS_BITS + 7) / 8) * 8;
    localparam int SW = STATUS_BITS;
    localparam int TW = TIMER_BITS;

    typedef struct packed {
        logic [SW-1:0] status;
        logic          from_click;
        logic          last;
    } t_result;

    // configuration registers
    logic [SW-1:0] r_hook_code, r_double_code, r_triple_code, r_enabled_mask;
    logic [TW-1:0] r_click_window, r_long_press;

    // input stage
    logic          r_in_valid;
    logic          r_in_op;
    logic [SW-1:0] r_in_status;

    // detector state
    logic          r_button_down, n_button_down;
    logic          r_long_fired, n_long_fired;
    logic [7:0]    r_click_count, n_click_count;
    logic          r_click_pending, n_click_pending;
    logic [TW-1:0] r_click_timer, n_click_timer;
    logic          r_long_pending, n_long_pending;
    logic [TW-1:0] r_long_timer, n_long_timer;
    logic          r_jack_bound, n_jack_bound;

    // output queue
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]     r_cnt;

    t_result       res0, res1;
    logic [1:0]    res_n;
    logic          pop;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;
    logic          long_exp;
    logic [SW-1:0] click_code;
    logic [FIFO_AW+1:0] room_need;

    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register read back
    always_comb begin
        unique case (cfg_idx)
            REG_HOOK_CODE:    prdata = 32'(r_hook_code);
            REG_DOUBLE_CODE:  prdata = 32'(r_double_code);
            REG_TRIPLE_CODE:  prdata = 32'(r_triple_code);
            REG_ENABLED_MASK: prdata = 32'(r_enabled_mask);
            REG_CLICK_WINDOW: prdata = 32'(r_click_window);
            REG_LONG_PRESS:   prdata = 32'(r_long_press);
            default:          prdata = 32'd0;
        endcase
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hook_code    <= SW'(HOOK_CODE_RST);
            r_double_code  <= SW'(DOUBLE_CODE_RST);
            r_triple_code  <= SW'(TRIPLE_CODE_RST);
            r_enabled_mask <= SW'(ENABLED_MASK_RST);
            r_click_window <= TW'(CLICK_WINDOW_RST);
            r_long_press   <= TW'(LONG_PRESS_RST);
        end else if (cfg_wr && pready) begin
            unique case (cfg_idx)
                REG_HOOK_CODE:    r_hook_code    <= SW'(pwdata[15:0]);
                REG_DOUBLE_CODE:  r_double_code  <= SW'(pwdata[15:0]);
                REG_TRIPLE_CODE:  r_triple_code  <= SW'(pwdata[15:0]);
                REG_ENABLED_MASK: r_enabled_mask <= SW'(pwdata[15:0]);
                REG_CLICK_WINDOW: r_click_window <= TW'(pwdata[15:0]);
                REG_LONG_PRESS:   r_long_press   <= TW'(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    // input register; accept only when the queue can absorb two words from
    // the word in flight and two from this one
    assign pop       = (r_cnt != '0) & i_m_axis_tready;
    assign room_need = (FIFO_AW + 2)'(r_cnt) - (FIFO_AW + 2)'(pop)
                     + (r_in_valid ? (FIFO_AW + 2)'(2) : '0) + (FIFO_AW + 2)'(2);
    assign o_s_axis_tready = (room_need <= (FIFO_AW + 2)'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_s_axis_tvalid & o_s_axis_tready;
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_op     <= i_s_axis_tuser;
            r_in_status <= i_s_axis_tdata[SW-1:0];
        end
    end

    // click code by count
    always_comb begin
        if (r_click_count <= 8'd1) begin
            click_code = r_hook_code;
        end else if (r_click_count == 8'd2) begin
            click_code = r_double_code;
        end else begin
            click_code = r_triple_code;
        end
    end

    assign long_exp = r_long_pending && (r_long_timer <= TW'(1));

    // detector update for the registered word
    always_comb begin
        n_button_down   = r_button_down;
        n_long_fired    = r_long_fired;
        n_click_count   = r_click_count;
        n_click_pending = r_click_pending;
        n_click_timer   = r_click_timer;
        n_long_pending  = r_long_pending;
        n_long_timer    = r_long_timer;
        n_jack_bound    = r_jack_bound;
        res0  = '{status: '0, from_click: 1'b0, last: 1'b0};
        res1  = '{status: '0, from_click: 1'b1, last: 1'b0};
        res_n = 2'd0;

        if (r_in_valid) begin
            if (r_in_op == OP_REPORT) begin
                if (r_in_status == r_hook_code && !r_button_down) begin
                    // press: arm long-press timer
                    n_jack_bound   = 1'b1;
                    n_button_down  = 1'b1;
                    n_long_pending = 1'b1;
                    n_long_timer   = r_long_press;
                end else if (r_in_status == '0 && r_button_down) begin
                    n_jack_bound  = 1'b1;
                    n_button_down = 1'b0;
                    if (!r_long_fired) begin
                        // short press: count a click, restart window
                        n_long_pending = 1'b0;
                        n_long_timer   = '0;
                        if (r_click_count == 8'd0) begin
                            n_click_count   = 8'd1;
                            n_click_pending = 1'b1;
                            n_click_timer   = r_click_window;
                        end else if (r_click_pending) begin
                            if (r_click_count != CLICK_MAX) begin
                                n_click_count = r_click_count + 8'd1;
                            end
                            n_click_timer = r_click_window;
                        end
                    end else begin
                        // release after long press passes through
                        n_long_fired = 1'b0;
                        res0.status  = '0;
                        res_n        = 2'd1;
                    end
                end else begin
                    // unrelated report
                    n_jack_bound = 1'b0;
                    res0.status  = r_in_status & r_enabled_mask;
                    res_n        = 2'd1;
                end
            end else begin
                if (long_exp) begin
                    // long press wins over the click window
                    n_long_pending  = 1'b0;
                    n_long_timer    = '0;
                    n_long_fired    = 1'b1;
                    n_click_pending = 1'b0;
                    n_click_timer   = '0;
                    n_click_count   = 8'd0;
                    if (r_jack_bound) begin
                        res0.status     = r_hook_code & r_enabled_mask;
                        res0.from_click = 1'b1;
                        res_n           = 2'd1;
                    end
                end else begin
                    if (r_long_pending) begin
                        n_long_timer = r_long_timer - TW'(1);
                    end
                    if (r_click_pending) begin
                        if (r_click_timer <= TW'(1)) begin
                            n_click_pending = 1'b0;
                            n_click_timer   = '0;
                            n_click_count   = 8'd0;
                            if (r_jack_bound) begin
                                res0.status     = click_code & r_enabled_mask;
                                res0.from_click = 1'b1;
                                res_n           = 2'd2;
                            end
                        end else begin
                            n_click_timer = r_click_timer - TW'(1);
                        end
                    end
                end
            end
        end

        // mark the final word of this item
        if (res_n == 2'd1) begin
            res0.last = 1'b1;
        end
        if (res_n == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_down   <= 1'b0;
            r_long_fired    <= 1'b0;
            r_click_count   <= 8'd0;
            r_click_pending <= 1'b0;
            r_click_timer   <= '0;
            r_long_pending  <= 1'b0;
            r_long_timer    <= '0;
            r_jack_bound    <= 1'b0;
        end else begin
            r_button_down   <= n_button_down;
            r_long_fired    <= n_long_fired;
            r_click_count   <= n_click_count;
            r_click_pending <= n_click_pending;
            r_click_timer   <= n_click_timer;
            r_long_pending  <= n_long_pending;
            r_long_timer    <= n_long_timer;
            r_jack_bound    <= n_jack_bound;
        end
    end

    // output queue storage
    always_ff @(posedge i_clk) begin
        if (res_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (res_n == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= res1;
        end
    end

    // output queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(res_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (FIFO_AW + 1)'(res_n) - (FIFO_AW + 1)'(pop);
        end
    end

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = DW'(r_fifo[r_rd_ptr].status);
    assign o_m_axis_tuser  = r_fifo[r_rd_ptr].from_click;
    assign o_m_axis_tlast  = r_fifo[r_rd_ptr].last;

    // queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("output queue overflow");

    // long-press timing or held state only with the button down
    a_long_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_long_pending || r_long_fired) |-> r_button_down)
        else $error("long-press state without button down");

    // a running click window always has a counted click
    a_click_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_click_pending |-> (r_click_count != 8'd0))
        else $error("click window without clicks");

    // a long-press expiry holds the button and closes the window
    a_long_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_op == OP_TICK && long_exp)
        |=> (r_long_fired && !r_click_pending && !r_long_pending))
        else $error("long-press expiry not taken");

endmodule
